@@ src/jsv_pkg.sv @@
// ----------------------------------------------------------------------------
// jsv_pkg: shared types and constants of the JSON stream validator
// Item layout passed from the byte classifier to the parser, result codes.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int OPEN_W = $clog2(MAX_DEPTH + 2);
  localparam int NEST_W = 6;

  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJ_HERE = 2'd2;
  localparam logic [1:0] ST_REJ_OLD  = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // classified item
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       ws;
    logic       digit;
    logic       hex_ok;
    logic [3:0] hex_d;
  } jsv_item_t;

endpackage

@@ src/jsv_if.sv @@
// ----------------------------------------------------------------------------
// jsv_if: stream channels of the JSON stream validator
// Input byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_req;
  modport source (output valid, kind, byte_req, input ready);
  modport sink (input valid, kind, byte_req, output ready);
endinterface

interface jsv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  nesting;
  logic [2:0]  decoded_count;
  logic [31:0] decoded_bytes;
  logic        in_key;
  modport source (output valid, status, nesting, decoded_count, decoded_bytes, in_key,
                  input ready);
  modport sink (input valid, status, nesting, decoded_count, decoded_bytes, in_key,
                output ready);
endinterface

@@ src/jsv_front.sv @@
// ----------------------------------------------------------------------------
// jsv_front: input stage
// Accepts items and registers them with their character class.
// ----------------------------------------------------------------------------
module jsv_front (
  input  logic               clk,
  input  logic               rst,
  jsv_in_if.sink             req,
  output logic               item_valid,
  output jsv_pkg::jsv_item_t item,
  input  logic               item_ready
);
  import jsv_pkg::*;

  logic       take;
  logic       hv;
  logic [3:0] hd;
  logic [7:0] b;

  assign req.ready = !item_valid || item_ready;
  assign take = req.valid && req.ready;
  assign b = req.byte_req;

  always_comb begin
    hv = 1'b1;
    hd = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hd = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hd = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hd = 4'(b - 8'h37);
    end else begin
      hv = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.kind   <= req.kind;
      item.data   <= b;
      item.ws     <= (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
      item.digit  <= (b >= 8'h30) && (b <= 8'h39);
      item.hex_ok <= hv;
      item.hex_d  <= hd;
    end
  end
endmodule

@@ src/jsv_fifo.sv @@
// ----------------------------------------------------------------------------
// jsv_fifo: two-entry item queue
// Decouples the input stage from the parser.
// ----------------------------------------------------------------------------
module jsv_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  input  jsv_pkg::jsv_item_t wr_item,
  output logic               wr_ready,
  output logic               rd_valid,
  output jsv_pkg::jsv_item_t rd_item,
  input  logic               rd_ready
);
  import jsv_pkg::*;

  jsv_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end
endmodule

@@ src/jsv_parser.sv @@
// ----------------------------------------------------------------------------
// jsv_parser: JSON grammar engine
// One classified item per cycle while the result side does not stall: mode
// machine, container stack, string decode to UTF-8, result register.
// ----------------------------------------------------------------------------
module jsv_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  jsv_pkg::jsv_item_t item,
  output logic               item_ready,
  jsv_out_if.source          rsp
);
  import jsv_pkg::*;

  typedef enum logic [22:0] {
    M_VALUE   = 23'h000001,
    M_AFTER   = 23'h000002,
    M_ARR_OPEN= 23'h000004,
    M_OBJ_OPEN= 23'h000008,
    M_OBJ_KEY = 23'h000010,
    M_OBJ_COL = 23'h000020,
    M_STR     = 23'h000040,
    M_ESC     = 23'h000080,
    M_HEX     = 23'h000100,
    M_LOW_BS  = 23'h000200,
    M_LOW_U   = 23'h000400,
    M_LOW_HEX = 23'h000800,
    M_LIT_T   = 23'h001000,
    M_LIT_F   = 23'h002000,
    M_LIT_N   = 23'h004000,
    M_N_MINUS = 23'h008000,
    M_N_ZERO  = 23'h010000,
    M_N_INT   = 23'h020000,
    M_N_DOT   = 23'h040000,
    M_N_FRAC  = 23'h080000,
    M_N_EXP   = 23'h100000,
    M_N_ESIGN = 23'h200000,
    M_N_EDIG  = 23'h400000
  } mode_t;

  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] word;
  } utf8_t;

  function automatic utf8_t enc(input logic [20:0] c);
    utf8_t r;
    r = '0;
    if (c < 21'h80) begin
      r.cnt = 3'd1;
      r.word = {24'd0, c[7:0]};
    end else if (c < 21'h800) begin
      r.cnt = 3'd2;
      r.word = {16'd0, 2'b10, c[5:0], 3'b110, c[10:6]};
    end else if (c < 21'h10000) begin
      r.cnt = 3'd3;
      r.word = {8'd0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end else begin
      r.cnt = 3'd4;
      r.word = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
    end
    return r;
  endfunction

  // expected letter of a literal; ok is low past its end
  function automatic logic [8:0] lit_char(input mode_t md, input logic [2:0] i);
    logic [8:0] r;
    r = '0;
    unique case (md)
      M_LIT_T: begin
        unique case (i)
          3'd1: r = {1'b1, 8'h72};
          3'd2: r = {1'b1, 8'h75};
          3'd3: r = {1'b1, 8'h65};
          default: r = '0;
        endcase
      end
      M_LIT_F: begin
        unique case (i)
          3'd1: r = {1'b1, 8'h61};
          3'd2: r = {1'b1, 8'h6C};
          3'd3: r = {1'b1, 8'h73};
          3'd4: r = {1'b1, 8'h65};
          default: r = '0;
        endcase
      end
      default: begin
        unique case (i)
          3'd1: r = {1'b1, 8'h75};
          3'd2: r = {1'b1, 8'h6C};
          3'd3: r = {1'b1, 8'h6C};
          default: r = '0;
        endcase
      end
    endcase
    return r;
  endfunction

  mode_t             mode, m;
  logic [MAX_DEPTH:0] stk, stk_next;
  logic [OPEN_W-1:0] open_cnt, open_next;
  logic [15:0]       hex_acc, hex_next;
  logic [9:0]        hi_sur, hi_next;
  logic [2:0]        hex_cnt, hcnt_next;
  logic [2:0]        lit_idx, lit_next;
  logic              failed, failed_next;
  logic              key_flag, key_next;

  logic        ok, handled, do_start, push, push_obj, pop;
  logic [1:0]  st;
  utf8_t       dec;
  logic [15:0] acc;
  logic [8:0]  lc;
  logic [7:0]  b;
  logic        is_e, top;
  logic        fire;

  assign item_ready = !rsp.valid || rsp.ready;
  assign fire = item_valid && item_ready;
  assign b = item.data;
  assign is_e = (b == 8'h65) || (b == 8'h45);
  assign top = stk[0];
  assign acc = {hex_acc[11:0], item.hex_d};
  assign lc = lit_char(mode, lit_idx);

  always_comb begin
    m = mode;
    stk_next = stk;
    open_next = open_cnt;
    hex_next = hex_acc;
    hi_next = hi_sur;
    hcnt_next = hex_cnt;
    lit_next = lit_idx;
    failed_next = failed;
    key_next = key_flag;
    ok = 1'b1;
    handled = 1'b0;
    do_start = 1'b0;
    push = 1'b0;
    push_obj = 1'b0;
    pop = 1'b0;
    dec = '0;
    st = ST_PENDING;
    if (item.kind == KIND_END) begin
      if (failed) begin
        st = ST_REJ_OLD;
      end else if (open_cnt == '0 && (mode == M_AFTER || mode == M_N_ZERO ||
                   mode == M_N_INT || mode == M_N_FRAC || mode == M_N_EDIG)) begin
        st = ST_ACCEPTED;
      end else begin
        st = ST_REJ_HERE;
      end
      m = M_VALUE;
      stk_next = '0;
      open_next = '0;
      hex_next = '0;
      hi_next = '0;
      hcnt_next = '0;
      lit_next = '0;
      failed_next = 1'b0;
      key_next = 1'b0;
    end else if (failed) begin
      st = ST_REJ_OLD;
    end else begin
      // number tokens; a byte that ends a complete number is reparsed
      unique case (mode)
        M_N_MINUS: begin
          handled = 1'b1;
          if (b == 8'h30) m = M_N_ZERO;
          else if (item.digit) m = M_N_INT;
          else ok = 1'b0;
        end
        M_N_ZERO, M_N_INT: begin
          handled = 1'b1;
          if (mode == M_N_INT && item.digit) m = M_N_INT;
          else if (b == 8'h2E) m = M_N_DOT;
          else if (is_e) m = M_N_EXP;
          else begin
            m = M_AFTER;
            handled = 1'b0;
          end
        end
        M_N_DOT: begin
          handled = 1'b1;
          if (item.digit) m = M_N_FRAC;
          else ok = 1'b0;
        end
        M_N_FRAC: begin
          handled = 1'b1;
          if (item.digit) m = M_N_FRAC;
          else if (is_e) m = M_N_EXP;
          else begin
            m = M_AFTER;
            handled = 1'b0;
          end
        end
        M_N_EXP: begin
          handled = 1'b1;
          if (b == 8'h2B || b == 8'h2D) m = M_N_ESIGN;
          else if (item.digit) m = M_N_EDIG;
          else ok = 1'b0;
        end
        M_N_ESIGN: begin
          handled = 1'b1;
          if (item.digit) m = M_N_EDIG;
          else ok = 1'b0;
        end
        M_N_EDIG: begin
          handled = !item.digit ? 1'b0 : 1'b1;
          if (!item.digit) m = M_AFTER;
        end
        default: ;
      endcase

      if (!handled) begin
        if (item.ws && (m == M_VALUE || m == M_AFTER || m == M_ARR_OPEN ||
                        m == M_OBJ_OPEN || m == M_OBJ_KEY || m == M_OBJ_COL)) begin
          ok = 1'b1;
        end else begin
          unique case (m)
            M_VALUE: do_start = 1'b1;
            M_ARR_OPEN: begin
              if (b == 8'h5D) pop = 1'b1;
              else do_start = 1'b1;
            end
            M_OBJ_OPEN, M_OBJ_KEY: begin
              if (m == M_OBJ_OPEN && b == 8'h7D) pop = 1'b1;
              else if (b == 8'h22) begin
                m = M_STR;
                key_next = 1'b1;
              end else ok = 1'b0;
            end
            M_OBJ_COL: begin
              if (b == 8'h3A) m = M_VALUE;
              else ok = 1'b0;
            end
            M_AFTER: begin
              if (open_cnt == '0) ok = 1'b0;
              else if (b == 8'h2C) m = top ? M_OBJ_KEY : M_VALUE;
              else if ((b == 8'h5D && !top) || (b == 8'h7D && top)) pop = 1'b1;
              else ok = 1'b0;
            end
            M_STR: begin
              if (b == 8'h22) begin
                m = key_flag ? M_OBJ_COL : M_AFTER;
                key_next = 1'b0;
              end else if (b < 8'h20) ok = 1'b0;
              else if (b == 8'h5C) m = M_ESC;
              else begin
                dec.cnt = 3'd1;
                dec.word = {24'd0, b};
              end
            end
            M_ESC: begin
              m = M_STR;
              dec.cnt = 3'd1;
              unique case (b)
                8'h22, 8'h5C, 8'h2F: dec.word = {24'd0, b};
                8'h62: dec.word = 32'h08;
                8'h66: dec.word = 32'h0C;
                8'h6E: dec.word = 32'h0A;
                8'h72: dec.word = 32'h0D;
                8'h74: dec.word = 32'h09;
                8'h75: begin
                  m = M_HEX;
                  dec = '0;
                  hex_next = '0;
                  hcnt_next = '0;
                end
                default: begin
                  ok = 1'b0;
                  dec = '0;
                end
              endcase
            end
            M_HEX, M_LOW_HEX: begin
              if (!item.hex_ok) ok = 1'b0;
              else begin
                hex_next = acc;
                if (hex_cnt != 3'd3) hcnt_next = hex_cnt + 3'd1;
                else begin
                  hcnt_next = '0;
                  if (m == M_HEX) begin
                    if (acc[15:10] == 6'b110110) begin
                      hi_next = acc[9:0];
                      m = M_LOW_BS;
                    end else if (acc[15:10] == 6'b110111) ok = 1'b0;
                    else begin
                      dec = enc({5'd0, acc});
                      m = M_STR;
                    end
                  end else begin
                    if (acc[15:10] != 6'b110111) ok = 1'b0;
                    else begin
                      dec = enc({1'b0, hi_sur, acc[9:0]} + 21'h10000);
                      m = M_STR;
                    end
                  end
                end
              end
            end
            M_LOW_BS: begin
              if (b == 8'h5C) m = M_LOW_U;
              else ok = 1'b0;
            end
            M_LOW_U: begin
              if (b == 8'h75) begin
                m = M_LOW_HEX;
                hex_next = '0;
                hcnt_next = '0;
              end else ok = 1'b0;
            end
            M_LIT_T, M_LIT_F, M_LIT_N: begin
              if (!lc[8] || b != lc[7:0]) ok = 1'b0;
              else if ((m == M_LIT_F && lit_idx == 3'd4) ||
                       (m != M_LIT_F && lit_idx == 3'd3)) begin
                m = M_AFTER;
                lit_next = '0;
              end else lit_next = lit_idx + 3'd1;
            end
            default: ok = 1'b0;
          endcase
        end

        if (do_start) begin
          if (open_cnt > OPEN_W'(MAX_DEPTH)) ok = 1'b0;
          else begin
            unique case (b)
              8'h7B: begin
                push = 1'b1;
                push_obj = 1'b1;
              end
              8'h5B: push = 1'b1;
              8'h22: begin
                m = M_STR;
                key_next = 1'b0;
              end
              8'h74: begin
                m = M_LIT_T;
                lit_next = 3'd1;
              end
              8'h66: begin
                m = M_LIT_F;
                lit_next = 3'd1;
              end
              8'h6E: begin
                m = M_LIT_N;
                lit_next = 3'd1;
              end
              8'h2D: m = M_N_MINUS;
              8'h30: m = M_N_ZERO;
              default: begin
                if (item.digit) m = M_N_INT;
                else ok = 1'b0;
              end
            endcase
          end
        end
        if (push) begin
          stk_next = {stk[MAX_DEPTH-1:0], push_obj};
          open_next = open_cnt + OPEN_W'(1);
          m = push_obj ? M_OBJ_OPEN : M_ARR_OPEN;
        end
        if (pop) begin
          stk_next = {1'b0, stk[MAX_DEPTH:1]};
          open_next = open_cnt - OPEN_W'(1);
          m = M_AFTER;
        end
      end

      if (!ok) begin
        m = mode;
        stk_next = stk;
        open_next = open_cnt;
        hex_next = hex_acc;
        hi_next = hi_sur;
        hcnt_next = hex_cnt;
        lit_next = lit_idx;
        key_next = key_flag;
        failed_next = 1'b1;
        dec = '0;
        st = ST_REJ_HERE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_VALUE;
      stk <= '0;
      open_cnt <= '0;
      hex_acc <= '0;
      hi_sur <= '0;
      hex_cnt <= '0;
      lit_idx <= '0;
      failed <= 1'b0;
      key_flag <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        mode <= m;
        stk <= stk_next;
        open_cnt <= open_next;
        hex_acc <= hex_next;
        hi_sur <= hi_next;
        hex_cnt <= hcnt_next;
        lit_idx <= lit_next;
        failed <= failed_next;
        key_flag <= key_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status <= st;
      rsp.nesting <= NEST_W'(open_next);
      rsp.decoded_count <= dec.cnt;
      rsp.decoded_bytes <= dec.word;
      rsp.in_key <= (dec.cnt != 3'd0) && key_next;
    end
  end
endmodule

@@ src/json_stream_validator.sv @@
// ----------------------------------------------------------------------------
// json_stream_validator: strict JSON document checker, one byte per item
// From input accept to result valid an item passes the input register, a queue
// entry, then the parser result register. Throughput: one item per cycle while
// the result side does not stall, with the two-entry queue before the parser.
// Reset (rst, synchronous): queue emptied, parser back to "expect root value".
// ----------------------------------------------------------------------------
module json_stream_validator (
  input  logic       clk,
  input  logic       rst,
  jsv_in_if.sink     req,
  jsv_out_if.source  rsp
);
  import jsv_pkg::*;

  // front: register and classify each incoming item
  logic      f_valid;
  jsv_item_t f_item;
  logic      f_ready;

  // queue output towards the parser
  logic      q_valid;
  jsv_item_t q_item;
  logic      q_ready;

  jsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  // short queue lets the front keep taking items while the result side stalls
  jsv_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_item  (f_item),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_ready (q_ready)
  );

  // back: grammar state, container stack, string decode, result register
  jsv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .rsp        (rsp)
  );
endmodule
